// ===== src/cuff_pkg.sv =====
`timescale 1ns / 1ps
// package for the central-upwind face flux block: op and operand codes,
// sequencer states, microcode table and saturating fixed-point helpers.
// no dependencies.
package cuff_pkg;

	// weight format is unsigned Q1.16
	localparam int W_FRAC = 16;
	localparam logic [16:0] W_ONE = 17'd65536;
	localparam logic [16:0] W_HALF = 17'd32768;
	localparam int UPC_W = 7;
	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_MAX, OP_MIN,
		OP_MULF, OP_MULH, OP_MULW, OP_MACC,
		OP_SQRT, OP_DIV, OP_END
	} op_t;

	// codes below 32 are input sources, codes from 32 are scratch memory entries
	typedef enum logic [5:0] {
		R_RHO_O = 6'd0, R_RHO_N, R_E_O, R_E_N, R_P_O, R_P_N, R_C_O, R_C_N, R_VM,
		R_S0, R_S1, R_S2, R_UO0, R_UO1, R_UO2, R_UN0, R_UN1, R_UN2,
		R_AR0, R_AR1, R_AR2, R_ZERO, R_W, R_WN,
		T_X = 6'd32, T_Y, T_G, T_EO, T_EN, T_PHO, T_PHN, T_T, T_CSO, T_CSN,
		T_AP, T_AM, T_ASF, T_AO, T_AN, T_PBAR, T_MO, T_MN, T_PHI, T_MASS,
		T_MOM0, T_MOM1, T_MOM2, T_ENG, T_FV0, T_FV1, T_FV2
	} opnd_t;

	typedef struct packed {
		op_t   op;
		opnd_t a;
		opnd_t b;
		opnd_t dst;
	} uinst_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_FETCH, ST_EXEC, ST_MUL, ST_RND, ST_SAT,
		ST_SQRT, ST_SQW, ST_DIV, ST_WRND, ST_DONE
	} state_t;

	function automatic uinst_t mk(input op_t o, input opnd_t a, input opnd_t b, input opnd_t d);
		uinst_t u;
		u = '{op: o, a: a, b: b, dst: d};
		return u;
	endfunction

	// microprogram for one face
	function automatic uinst_t ucode(input logic [UPC_W-1:0] pc);
		uinst_t u;
		unique case (pc)
			// area magnitude
			7'd0:  u = mk(OP_MACC, R_AR0, R_AR0, R_ZERO);
			7'd1:  u = mk(OP_MACC, R_AR1, R_AR1, R_ZERO);
			7'd2:  u = mk(OP_MACC, R_AR2, R_AR2, R_ZERO);
			7'd3:  u = mk(OP_SQRT, R_ZERO, R_ZERO, T_T);
			// total energies
			7'd4:  u = mk(OP_MULH, R_UO0, R_UO0, T_X);
			7'd5:  u = mk(OP_ADD, R_E_O, T_X, T_EO);
			7'd6:  u = mk(OP_MULH, R_UO1, R_UO1, T_X);
			7'd7:  u = mk(OP_ADD, T_EO, T_X, T_EO);
			7'd8:  u = mk(OP_MULH, R_UO2, R_UO2, T_X);
			7'd9:  u = mk(OP_ADD, T_EO, T_X, T_EO);
			7'd10: u = mk(OP_MULH, R_UN0, R_UN0, T_X);
			7'd11: u = mk(OP_ADD, R_E_N, T_X, T_EN);
			7'd12: u = mk(OP_MULH, R_UN1, R_UN1, T_X);
			7'd13: u = mk(OP_ADD, T_EN, T_X, T_EN);
			7'd14: u = mk(OP_MULH, R_UN2, R_UN2, T_X);
			7'd15: u = mk(OP_ADD, T_EN, T_X, T_EN);
			// relative volume fluxes
			7'd16: u = mk(OP_MULF, R_UO0, R_S0, T_PHO);
			7'd17: u = mk(OP_MULF, R_UO1, R_S1, T_X);
			7'd18: u = mk(OP_ADD, T_PHO, T_X, T_PHO);
			7'd19: u = mk(OP_MULF, R_UO2, R_S2, T_X);
			7'd20: u = mk(OP_ADD, T_PHO, T_X, T_PHO);
			7'd21: u = mk(OP_SUB, T_PHO, R_VM, T_PHO);
			7'd22: u = mk(OP_MULF, R_UN0, R_S0, T_PHN);
			7'd23: u = mk(OP_MULF, R_UN1, R_S1, T_X);
			7'd24: u = mk(OP_ADD, T_PHN, T_X, T_PHN);
			7'd25: u = mk(OP_MULF, R_UN2, R_S2, T_X);
			7'd26: u = mk(OP_ADD, T_PHN, T_X, T_PHN);
			7'd27: u = mk(OP_SUB, T_PHN, R_VM, T_PHN);
			// wave speeds
			7'd28: u = mk(OP_MULF, R_C_O, T_T, T_CSO);
			7'd29: u = mk(OP_MULF, R_C_N, T_T, T_CSN);
			7'd30: u = mk(OP_ADD, T_PHO, T_CSO, T_X);
			7'd31: u = mk(OP_ADD, T_PHN, T_CSN, T_Y);
			7'd32: u = mk(OP_MAX, T_X, T_Y, T_AP);
			7'd33: u = mk(OP_MAX, T_AP, R_ZERO, T_AP);
			7'd34: u = mk(OP_SUB, T_PHO, T_CSO, T_X);
			7'd35: u = mk(OP_SUB, T_PHN, T_CSN, T_Y);
			7'd36: u = mk(OP_MIN, T_X, T_Y, T_AM);
			7'd37: u = mk(OP_MIN, T_AM, R_ZERO, T_AM);
			// weights and weighted fluxes
			7'd38: u = mk(OP_DIV, T_AP, T_AM, R_ZERO);
			7'd39: u = mk(OP_MULW, T_AM, R_W, T_ASF);
			7'd40: u = mk(OP_MULW, T_PHO, R_W, T_X);
			7'd41: u = mk(OP_SUB, T_X, T_ASF, T_AO);
			7'd42: u = mk(OP_MULW, T_PHN, R_WN, T_X);
			7'd43: u = mk(OP_ADD, T_X, T_ASF, T_AN);
			7'd44: u = mk(OP_MULW, R_P_O, R_W, T_X);
			7'd45: u = mk(OP_MULW, R_P_N, R_WN, T_Y);
			7'd46: u = mk(OP_ADD, T_X, T_Y, T_PBAR);
			7'd47: u = mk(OP_MULF, T_AO, R_RHO_O, T_MO);
			7'd48: u = mk(OP_MULF, T_AN, R_RHO_N, T_MN);
			7'd49: u = mk(OP_ADD, T_AO, T_AN, T_PHI);
			7'd50: u = mk(OP_ADD, T_MO, T_MN, T_MASS);
			// momentum
			7'd51: u = mk(OP_MULF, T_MO, R_UO0, T_X);
			7'd52: u = mk(OP_MULF, T_MN, R_UN0, T_Y);
			7'd53: u = mk(OP_ADD, T_X, T_Y, T_X);
			7'd54: u = mk(OP_MULF, T_PBAR, R_S0, T_Y);
			7'd55: u = mk(OP_ADD, T_X, T_Y, T_MOM0);
			7'd56: u = mk(OP_MULF, T_MO, R_UO1, T_X);
			7'd57: u = mk(OP_MULF, T_MN, R_UN1, T_Y);
			7'd58: u = mk(OP_ADD, T_X, T_Y, T_X);
			7'd59: u = mk(OP_MULF, T_PBAR, R_S1, T_Y);
			7'd60: u = mk(OP_ADD, T_X, T_Y, T_MOM1);
			7'd61: u = mk(OP_MULF, T_MO, R_UO2, T_X);
			7'd62: u = mk(OP_MULF, T_MN, R_UN2, T_Y);
			7'd63: u = mk(OP_ADD, T_X, T_Y, T_X);
			7'd64: u = mk(OP_MULF, T_PBAR, R_S2, T_Y);
			7'd65: u = mk(OP_ADD, T_X, T_Y, T_MOM2);
			// face velocity
			7'd66: u = mk(OP_MULW, R_UO0, R_W, T_X);
			7'd67: u = mk(OP_MULW, R_UN0, R_WN, T_Y);
			7'd68: u = mk(OP_ADD, T_X, T_Y, T_FV0);
			7'd69: u = mk(OP_MULW, R_UO1, R_W, T_X);
			7'd70: u = mk(OP_MULW, R_UN1, R_WN, T_Y);
			7'd71: u = mk(OP_ADD, T_X, T_Y, T_FV1);
			7'd72: u = mk(OP_MULW, R_UO2, R_W, T_X);
			7'd73: u = mk(OP_MULW, R_UN2, R_WN, T_Y);
			7'd74: u = mk(OP_ADD, T_X, T_Y, T_FV2);
			// energy
			7'd75: u = mk(OP_MULF, R_RHO_O, T_EO, T_X);
			7'd76: u = mk(OP_ADD, T_X, R_P_O, T_X);
			7'd77: u = mk(OP_MULF, T_AO, T_X, T_G);
			7'd78: u = mk(OP_MULF, R_RHO_N, T_EN, T_X);
			7'd79: u = mk(OP_ADD, T_X, R_P_N, T_X);
			7'd80: u = mk(OP_MULF, T_AN, T_X, T_X);
			7'd81: u = mk(OP_ADD, T_G, T_X, T_G);
			7'd82: u = mk(OP_MULF, T_ASF, R_P_O, T_X);
			7'd83: u = mk(OP_ADD, T_G, T_X, T_G);
			7'd84: u = mk(OP_MULF, T_ASF, R_P_N, T_X);
			7'd85: u = mk(OP_SUB, T_G, T_X, T_G);
			7'd86: u = mk(OP_MULF, R_VM, T_PBAR, T_X);
			7'd87: u = mk(OP_ADD, T_G, T_X, T_ENG);
			default: u = mk(OP_END, R_ZERO, R_ZERO, R_ZERO);
		endcase
		return u;
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] x);
		return x[63] ? 64'(64'd0 - x) : x;
	endfunction

	// move between fraction widths: rounding (ties away) down, saturating up
	function automatic logic signed [63:0] align_frac(input logic signed [63:0] x,
		input int from_f, input int to_f);
		int d;
		logic [64:0] m;
		logic signed [63:0] lim;
		logic signed [63:0] r;
		d = to_f - from_f;
		r = x;
		if (d < 0) begin
			m = x[63] ? (65'd0 - {x[63], x}) : {1'b0, x};
			m = (m + (65'd1 << (-d - 1))) >> (-d);
			r = x[63] ? 64'(64'd0 - m[63:0]) : m[63:0];
		end else if (d > 0) begin
			lim = S64_MAX >>> d;
			if (x > lim) r = S64_MAX;
			else if (x < -lim - 64'sd1) r = S64_MIN;
			else r = x <<< d;
		end
		return r;
	endfunction

	// wide face velocity down to the input format, clamped to 32 bits
	function automatic logic signed [31:0] fv_narrow(input logic signed [63:0] x,
		input int from_f, input int to_f);
		logic signed [63:0] r;
		r = align_frac(x, from_f, to_f);
		if (r > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (r < -64'sd2147483648) return 32'sh8000_0000;
		return r[31:0];
	endfunction

endpackage

// ===== src/central_upwind_face_flux.sv =====
`timescale 1ns / 1ps
// top level of the central-upwind face flux block: item capture, microcoded
// sequencer, shared 32x32 multiplier, sqrt and divider steps, result register.
// depends on cuff_pkg.
//
// A face is two items. An owner item (side 0) is stored and gives no result.
// A neighbor item (side 1) starts the face computation; the input stalls
// until it is done. The time is set by the single 32x32 multiplier: each of
// the 43 rounded 64-bit products and the three area squares is built from
// four partial products, the area square root takes 32 one-bit steps and the
// owner weight 17 restoring division steps, all run in turn by the microcode
// sequencer. The finished result waits in its own output register, so the
// next owner and neighbor items can be taken while it is still stalled.
module central_upwind_face_flux
	import cuff_pkg::*;
#(
	parameter int IN_FRAC_BITS = 16,
	parameter int OUT_FRAC_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               side,
	input  logic [30:0]        density,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	input  logic signed [31:0] internal_energy,
	input  logic signed [31:0] pressure,
	input  logic [30:0]        sound_speed,
	input  logic signed [31:0] area_x,
	input  logic signed [31:0] area_y,
	input  logic signed [31:0] area_z,
	input  logic signed [31:0] mesh_flux,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] volume_flux,
	output logic signed [63:0] mass_flux,
	output logic signed [63:0] momentum_flux_x,
	output logic signed [63:0] momentum_flux_y,
	output logic signed [63:0] momentum_flux_z,
	output logic signed [63:0] energy_flux_out,
	output logic [16:0]        owner_weight,
	output logic signed [63:0] wave_flux,
	output logic signed [31:0] face_vel_x,
	output logic signed [31:0] face_vel_y,
	output logic signed [31:0] face_vel_z
);

	localparam int SH_F = OUT_FRAC_BITS;
	localparam int SH_H = OUT_FRAC_BITS + 1;
	localparam int SH_W = W_FRAC;

	state_t state_q, state_d;
	logic [UPC_W-1:0] pc_q;
	logic [4:0] cnt_q;
	uinst_t cur;

	// held owner item and captured neighbor item
	logic [30:0] held_density_q, held_sound_speed_q;
	logic signed [31:0] held_vel_x_q, held_vel_y_q, held_vel_z_q;
	logic signed [31:0] held_energy_q, held_pressure_q;
	logic signed [31:0] held_area_x_q, held_area_y_q, held_area_z_q, held_mesh_flux_q;
	logic [30:0] nb_density_q, nb_sound_speed_q;
	logic signed [31:0] nb_vel_x_q, nb_vel_y_q, nb_vel_z_q, nb_energy_q, nb_pressure_q;

	logic signed [63:0] srcv [32];
	logic signed [63:0] tmem [32];
	logic signed [63:0] opa_q, opb_q;

	// multiplier
	logic [63:0] ma_q, mb_q;
	logic neg_q;
	logic [127:0] acc_q, acc_sum, pp_sh, rnd, shifted;
	logic [31:0] pa, pb;
	logic [63:0] pp;
	logic signed [63:0] mul_sat;

	// sqrt and divider
	logic [63:0] sq_q, v_q, rt_q, bit_q, sq_t;
	logic sq_ge;
	logic [63:0] den_q, r_q, div_rs;
	logic [17:0] q_q, div_qs, q_rnd;
	logic div_ge;
	logic [16:0] w_q, wn_q, w_d;

	// write port and alu
	logic wr_en;
	logic signed [63:0] wr_data, alu_res;

	// result registers
	logic signed [63:0] res_phi_q, res_mass_q, res_mom0_q, res_mom1_q, res_mom2_q;
	logic signed [63:0] res_eng_q, res_wave_q, res_fv0_q, res_fv1_q, res_fv2_q;
	logic out_valid_q;

	logic in_acc;
	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign cur = ucode(pc_q);

	// held owner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_density_q <= '0;
			held_sound_speed_q <= '0;
			held_vel_x_q <= '0;
			held_vel_y_q <= '0;
			held_vel_z_q <= '0;
			held_energy_q <= '0;
			held_pressure_q <= '0;
			held_area_x_q <= '0;
			held_area_y_q <= '0;
			held_area_z_q <= '0;
			held_mesh_flux_q <= '0;
		end else if (in_acc && !side) begin
			held_density_q <= density;
			held_sound_speed_q <= sound_speed;
			held_vel_x_q <= vel_x;
			held_vel_y_q <= vel_y;
			held_vel_z_q <= vel_z;
			held_energy_q <= internal_energy;
			held_pressure_q <= pressure;
			held_area_x_q <= area_x;
			held_area_y_q <= area_y;
			held_area_z_q <= area_z;
			held_mesh_flux_q <= mesh_flux;
		end
	end

	// source operands, widened to the internal format
	always_comb begin
		for (int i = 0; i < 32; i++) srcv[i] = '0;
		srcv[5'(R_RHO_O)] = align_frac({33'd0, held_density_q}, IN_FRAC_BITS, OUT_FRAC_BITS);
		srcv[5'(R_RHO_N)] = align_frac({33'd0, nb_density_q}, IN_FRAC_BITS, OUT_FRAC_BITS);
		srcv[5'(R_E_O)] = align_frac(64'(held_energy_q), IN_FRAC_BITS, OUT_FRAC_BITS);
		srcv[5'(R_E_N)] = align_frac(64'(nb_energy_q), IN_FRAC_BITS, OUT_FRAC_BITS);
		srcv[5'(R_P_O)] = align_frac(64'(held_pressure_q), IN_FRAC_BITS, OUT_FRAC_BITS);
		srcv[5'(R_P_N)] = align_frac(64'(nb_pressure_q), IN_FRAC_BITS, OUT_FRAC_BITS);
		srcv[5'(R_C_O)] = align_frac({33'd0, held_sound_speed_q}, IN_FRAC_BITS,
			OUT_FRAC_BITS);
		srcv[5'(R_C_N)] = align_frac({33'd0, nb_sound_speed_q}, IN_FRAC_BITS, OUT_FRAC_BITS);
		srcv[5'(R_VM)] = align_frac(64'(held_mesh_flux_q), IN_FRAC_BITS, OUT_FRAC_BITS);
		srcv[5'(R_S0)] = align_frac(64'(held_area_x_q), IN_FRAC_BITS, OUT_FRAC_BITS);
		srcv[5'(R_S1)] = align_frac(64'(held_area_y_q), IN_FRAC_BITS, OUT_FRAC_BITS);
		srcv[5'(R_S2)] = align_frac(64'(held_area_z_q), IN_FRAC_BITS, OUT_FRAC_BITS);
		srcv[5'(R_UO0)] = align_frac(64'(held_vel_x_q), IN_FRAC_BITS, OUT_FRAC_BITS);
		srcv[5'(R_UO1)] = align_frac(64'(held_vel_y_q), IN_FRAC_BITS, OUT_FRAC_BITS);
		srcv[5'(R_UO2)] = align_frac(64'(held_vel_z_q), IN_FRAC_BITS, OUT_FRAC_BITS);
		srcv[5'(R_UN0)] = align_frac(64'(nb_vel_x_q), IN_FRAC_BITS, OUT_FRAC_BITS);
		srcv[5'(R_UN1)] = align_frac(64'(nb_vel_y_q), IN_FRAC_BITS, OUT_FRAC_BITS);
		srcv[5'(R_UN2)] = align_frac(64'(nb_vel_z_q), IN_FRAC_BITS, OUT_FRAC_BITS);
		srcv[5'(R_AR0)] = 64'(held_area_x_q);
		srcv[5'(R_AR1)] = 64'(held_area_y_q);
		srcv[5'(R_AR2)] = 64'(held_area_z_q);
		srcv[5'(R_W)] = {47'd0, w_q};
		srcv[5'(R_WN)] = {47'd0, wn_q};
	end

	// scratch memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (wr_en) tmem[cur.dst[4:0]] <= wr_data;
		if (state_q == ST_FETCH) begin
			opa_q <= cur.a[5] ? tmem[cur.a[4:0]] : srcv[cur.a[4:0]];
			opb_q <= cur.b[5] ? tmem[cur.b[4:0]] : srcv[cur.b[4:0]];
		end
	end

	// alu for add, subtract, max and min
	always_comb begin
		case (cur.op)
			OP_SUB:  alu_res = sat_sub(opa_q, opb_q);
			OP_MAX:  alu_res = (opb_q > opa_q) ? opb_q : opa_q;
			OP_MIN:  alu_res = (opb_q < opa_q) ? opb_q : opa_q;
			default: alu_res = sat_add(opa_q, opb_q);
		endcase
	end

	// partial products, rounding and saturation of the shared multiplier
	always_comb begin
		pa = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
		pb = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
		pp = {32'd0, pa} * {32'd0, pb};
		case (cnt_q[1:0])
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
		acc_sum = acc_q + pp_sh;
		case (cur.op)
			OP_MULH: begin
				rnd = 128'd1 << (SH_H - 1);
				shifted = acc_q >> SH_H;
			end
			OP_MULW: begin
				rnd = 128'd1 << (SH_W - 1);
				shifted = acc_q >> SH_W;
			end
			default: begin
				rnd = 128'd1 << (SH_F - 1);
				shifted = acc_q >> SH_F;
			end
		endcase
		if (neg_q) mul_sat = (shifted[127:63] != '0) ? S64_MIN : 64'(64'd0 - shifted[63:0]);
		else mul_sat = (shifted[127:63] != '0) ? S64_MAX : shifted[63:0];
	end

	// square root and division steps
	always_comb begin
		sq_t = rt_q + bit_q;
		sq_ge = (v_q >= sq_t);
		div_rs = (cnt_q == 5'd0) ? r_q : {r_q[62:0], 1'b0};
		div_qs = (cnt_q == 5'd0) ? q_q : {q_q[16:0], 1'b0};
		div_ge = (div_rs >= den_q);
		q_rnd = q_q + 18'(({r_q, 1'b0}) >= {1'b0, den_q});
		if (den_q == '0) w_d = W_HALF;
		else if (q_rnd > 18'(W_ONE)) w_d = W_ONE;
		else w_d = q_rnd[16:0];
	end

	// scratch write port
	always_comb begin
		wr_en = 1'b0;
		wr_data = alu_res;
		case (state_q)
			ST_EXEC: begin
				wr_en = (cur.op == OP_ADD) || (cur.op == OP_SUB) ||
					(cur.op == OP_MAX) || (cur.op == OP_MIN);
			end
			ST_SAT: begin
				wr_en = 1'b1;
				wr_data = mul_sat;
			end
			ST_SQW: begin
				wr_en = 1'b1;
				wr_data = align_frac(rt_q, IN_FRAC_BITS, OUT_FRAC_BITS);
			end
			default: ;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc && side) begin
			nb_density_q <= density;
			nb_sound_speed_q <= sound_speed;
			nb_vel_x_q <= vel_x;
			nb_vel_y_q <= vel_y;
			nb_vel_z_q <= vel_z;
			nb_energy_q <= internal_energy;
			nb_pressure_q <= pressure;
			sq_q <= '0;
		end
		case (state_q)
			ST_EXEC: begin
				ma_q <= mag64(opa_q);
				mb_q <= mag64(opb_q);
				neg_q <= opa_q[63] ^ opb_q[63];
				acc_q <= '0;
				v_q <= sq_q;
				rt_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
				den_q <= sat_sub(opa_q, opb_q);
				r_q <= opa_q;
				q_q <= '0;
			end
			ST_MUL: begin
				acc_q <= acc_sum;
				if (cnt_q == 5'd3 && cur.op == OP_MACC) sq_q <= sq_q + acc_sum[63:0];
			end
			ST_RND: acc_q <= acc_q + rnd;
			ST_SQRT: begin
				if (sq_ge) begin
					v_q <= v_q - sq_t;
					rt_q <= (rt_q >> 1) + bit_q;
				end else begin
					rt_q <= rt_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_DIV: begin
				if (div_ge) begin
					r_q <= div_rs - den_q;
					q_q <= div_qs | 18'd1;
				end else begin
					r_q <= div_rs;
					q_q <= div_qs;
				end
			end
			ST_WRND: begin
				w_q <= w_d;
				wn_q <= W_ONE - w_d;
			end
			default: ;
		endcase
		// results latch as they are written
		if (wr_en) begin
			unique case (cur.dst)
				T_PHI:  res_phi_q <= wr_data;
				T_MASS: res_mass_q <= wr_data;
				T_MOM0: res_mom0_q <= wr_data;
				T_MOM1: res_mom1_q <= wr_data;
				T_MOM2: res_mom2_q <= wr_data;
				T_ENG:  res_eng_q <= wr_data;
				T_ASF:  res_wave_q <= wr_data;
				T_FV0:  res_fv0_q <= wr_data;
				T_FV1:  res_fv1_q <= wr_data;
				T_FV2:  res_fv2_q <= wr_data;
				default: ;
			endcase
		end
	end

	// sequencer state, program counter and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc && side) pc_q <= '0;
			else if (state_d == ST_FETCH && state_q != ST_IDLE && state_q != ST_FETCH)
				pc_q <= pc_q + 1'b1;
			if (state_q == ST_EXEC) cnt_q <= '0;
			else if (state_q == ST_MUL || state_q == ST_SQRT || state_q == ST_DIV)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid && side) state_d = ST_FETCH;
			ST_FETCH: state_d = (cur.op == OP_END) ? ST_DONE : ST_EXEC;
			ST_EXEC: begin
				unique case (cur.op) inside
					OP_MULF, OP_MULH, OP_MULW, OP_MACC: state_d = ST_MUL;
					OP_SQRT: state_d = ST_SQRT;
					OP_DIV:  state_d = ST_DIV;
					default: state_d = ST_FETCH;
				endcase
			end
			ST_MUL: if (cnt_q == 5'd3) state_d = (cur.op == OP_MACC) ? ST_FETCH : ST_RND;
			ST_RND:  state_d = ST_SAT;
			ST_SAT:  state_d = ST_FETCH;
			ST_SQRT: if (cnt_q == 5'd31) state_d = ST_SQW;
			ST_SQW:  state_d = ST_FETCH;
			ST_DIV:  if (cnt_q == 5'd16) state_d = ST_WRND;
			ST_WRND: state_d = ST_FETCH;
			ST_DONE: if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			volume_flux <= res_phi_q;
			mass_flux <= res_mass_q;
			momentum_flux_x <= res_mom0_q;
			momentum_flux_y <= res_mom1_q;
			momentum_flux_z <= res_mom2_q;
			energy_flux_out <= res_eng_q;
			owner_weight <= w_q;
			wave_flux <= res_wave_q;
			face_vel_x <= fv_narrow(res_fv0_q, OUT_FRAC_BITS, IN_FRAC_BITS);
			face_vel_y <= fv_narrow(res_fv1_q, OUT_FRAC_BITS, IN_FRAC_BITS);
			face_vel_z <= fv_narrow(res_fv2_q, OUT_FRAC_BITS, IN_FRAC_BITS);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/cuff_check.sv =====
`timescale 1ns / 1ps
// port-level checker for the central-upwind face flux block and its bind.
// depends on central_upwind_face_flux.
module cuff_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               side,
	input logic               out_valid,
	input logic               out_stall,
	input logic [16:0]        owner_weight,
	input logic signed [63:0] volume_flux
);

	// a stalled result item stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(volume_flux))
		else $error("result item changed while stalled");

	// weight never exceeds one
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> owner_weight <= 17'd65536)
		else $error("owner weight above one");

	// owner item is stored without blocking the input
	a_owner_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !side |=> !in_stall)
		else $error("input stalled after owner item");

	// neighbor item starts a computation that holds off the input
	a_neighbor_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && side |=> in_stall)
		else $error("input not stalled after neighbor item");

endmodule

bind central_upwind_face_flux cuff_check u_cuff_check (.*);
